@@ hdl/u16u8_pkg.sv @@
package u16u8_pkg;

    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int JOB_BYTES  = 6;
    localparam int CNT_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;

    typedef struct packed {
        logic [3:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]       len;
    } enc_t;

    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic                             last;
    } job_t;

    function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e = '0;
        if (cp < 21'h80)
        begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp < SUPP_BASE)
        begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end
        else
        begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ hdl/u16u8_front.sv @@
module u16u8_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [u16u8_pkg::UNIT_W-1:0] unit,
    input  logic                       unit_last,
    output logic                       push,
    output u16u8_pkg::job_t            job
);
    import u16u8_pkg::*;

    logic [UNIT_W-1:0] held_high_reg;
    logic [UNIT_W-1:0] held_high_next;
    logic              held_valid_reg;
    logic              held_valid_next;

    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        flush;
    logic        hold_new;
    logic        cur_emit;
    logic [CP_W-1:0] pair_cp;
    enc_t        held_enc;
    enc_t        cur_enc;
    enc_t        pair_enc;

    always_comb
    begin
        is_high  = unit inside {[HIGH_FIRST:HIGH_LAST]};
        is_low   = unit inside {[LOW_FIRST:LOW_LAST]};
        pair     = held_valid_reg && is_low;
        flush    = held_valid_reg && !is_low;
        hold_new = !pair && is_high && !unit_last;
        cur_emit = !pair && !hold_new;

        pair_cp  = SUPP_BASE + {1'b0, held_high_reg[9:0], unit[9:0]};
        held_enc = encode_cp({5'd0, held_high_reg});
        cur_enc  = encode_cp({5'd0, unit});
        pair_enc = encode_cp(pair_cp);

        job = '0;
        job.last = unit_last;
        if (pair)
        begin
            job.bytes[3:0] = pair_enc.bytes;
            job.count      = pair_enc.len;
        end
        else if (flush)
        begin
            job.bytes[2:0] = held_enc.bytes[2:0];
            if (cur_emit)
            begin
                job.bytes[5:3] = cur_enc.bytes[2:0];
                job.count      = held_enc.len + cur_enc.len;
            end
            else
            begin
                job.count = held_enc.len;
            end
        end
        else if (cur_emit)
        begin
            job.bytes[3:0] = cur_enc.bytes;
            job.count      = cur_enc.len;
        end

        push = accept && (job.count != '0);

        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (accept)
        begin
            held_valid_next = hold_new;
            held_high_next  = hold_new ? unit : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

@@ hdl/u16u8_queue.sv @@
module u16u8_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u16u8_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output u16u8_pkg::job_t head
);
    import u16u8_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    job_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        full     = (fill_reg == FILL_W'(QUEUE_DEPTH));
        nonempty = (fill_reg != '0);
        head     = mem[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && nonempty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ hdl/u16u8_back.sv @@
module u16u8_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_avail,
    input  u16u8_pkg::job_t              job_in,
    output logic                         job_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [u16u8_pkg::BYTE_W-1:0] out_byte,
    output logic                         out_run_last,
    output logic                         out_string_end
);
    import u16u8_pkg::*;

    job_t             job_reg;
    job_t             job_next;
    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             final_byte;
    logic             beat;

    always_comb
    begin
        final_byte     = (idx_reg == job_reg.count - 1'b1);
        beat           = busy_reg && out_ready;
        out_valid      = busy_reg;
        out_byte       = job_reg.bytes[idx_reg];
        out_run_last   = final_byte;
        out_string_end = final_byte && job_reg.last;

        job_pop   = job_avail && (!busy_reg || (beat && final_byte));
        job_next  = job_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (job_pop)
        begin
            job_next  = job_in;
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (beat)
        begin
            if (final_byte)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

@@ hdl/utf16_to_utf8_transcoder.sv @@
// Channel   Direction  tdata            tuser       tlast
// s_axis    in         code_unit[15:0]  -           string_last
// m_axis    out        out_byte[7:0]    run_last    string_end
//
// Each UTF-8 byte takes one output beat, so a unit yields one to three bytes,
// a surrogate pair four bytes for both units, and a flushed lone high surrogate
// with the unit after it up to six; the byte serializer in the back end sends them.
// The front end classifies a unit and stores its bytes in a two-entry job queue,
// so input is taken while earlier bytes still drain; s_axis_tready drops only
// when the queue is full. Reset clears the held surrogate, the queue and the
// serializer at once.
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // code_unit[15:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic [0:0]  m_axis_tuser,   // run_last[0]
    output logic        m_axis_tlast
);
    import u16u8_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic nonempty;
    logic run_last;
    job_t front_job;
    job_t head_job;

    assign s_axis_tready   = !full;
    assign accept          = s_axis_tvalid && !full;
    assign m_axis_tuser[0] = run_last;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .unit      (s_axis_tdata),
        .unit_last (s_axis_tlast),
        .push      (push),
        .job       (front_job)
    );

    u16u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .head     (head_job)
    );

    u16u8_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_avail      (nonempty),
        .job_in         (head_job),
        .job_pop        (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_run_last   (run_last),
        .out_string_end (m_axis_tlast)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import u16u8_pkg::*;

    localparam int N_DIR       = 23;
    localparam int RAND_UNITS  = 107;
    localparam int CALM_UNITS  = 30;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } utf8_beat_t;

    // A nonzero byte count means the bytes are written out here, first byte highest.
    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic [1:0]  nexp;
        logic [23:0] bytes;
    } dir_row_t;

    dir_row_t dir_rows [N_DIR] = '{
        {16'h0000, 1'b1, 2'd1, 24'h00_00_00},
        {16'h007F, 1'b0, 2'd1, 24'h7F_00_00},
        {16'h0080, 1'b0, 2'd2, 24'hC2_80_00},
        {16'h07FF, 1'b0, 2'd2, 24'hDF_BF_00},
        {16'h0800, 1'b0, 2'd3, 24'hE0_A0_80},
        {16'hFFFF, 1'b1, 2'd3, 24'hEF_BF_BF},
        {16'hD800, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDC00, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDBFF, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDFFF, 1'b1, 2'd0, 24'h00_00_00},
        {16'hD83D, 1'b0, 2'd0, 24'h00_00_00},
        {16'h0041, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDABC, 1'b0, 2'd0, 24'h00_00_00},
        {16'hD9FF, 1'b0, 2'd0, 24'h00_00_00},
        {16'h07FF, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDBFF, 1'b0, 2'd0, 24'h00_00_00},
        {16'hFFFF, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDB00, 1'b1, 2'd0, 24'h00_00_00},
        {16'hDC00, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDFFF, 1'b1, 2'd0, 24'h00_00_00},
        {16'hD800, 1'b0, 2'd0, 24'h00_00_00},
        {16'hDBFF, 1'b1, 2'd0, 24'h00_00_00},
        {16'hE000, 1'b1, 2'd0, 24'h00_00_00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    utf8_beat_t  pending_beats [$];
    logic [15:0] held_unit = 16'h0000;
    logic        held_ok = 1'b0;
    logic [7:0]  step_bytes [0:5];
    int          step_n;
    int          units_taken = 0;
    int          units_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;
    bit          jitter_on = 1'b0;
    bit          long_hold_pending = 1'b0;

    utf16_to_utf8_transcoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic void append_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            step_bytes[step_n] = cp[7:0];
            step_n++;
        end
        else if (cp < 21'h800)
        begin
            step_bytes[step_n]     = {3'b110, cp[10:6]};
            step_bytes[step_n + 1] = {2'b10, cp[5:0]};
            step_n += 2;
        end
        else if (cp < 21'h10000)
        begin
            step_bytes[step_n]     = {4'b1110, cp[15:12]};
            step_bytes[step_n + 1] = {2'b10, cp[11:6]};
            step_bytes[step_n + 2] = {2'b10, cp[5:0]};
            step_n += 3;
        end
        else
        begin
            step_bytes[step_n]     = {5'b11110, cp[20:18]};
            step_bytes[step_n + 1] = {2'b10, cp[17:12]};
            step_bytes[step_n + 2] = {2'b10, cp[11:6]};
            step_bytes[step_n + 3] = {2'b10, cp[5:0]};
            step_n += 4;
        end
    endfunction

    function automatic void transcode_unit(input logic [15:0] unit, input logic last);
        logic [20:0] hi_off;
        logic [20:0] lo_off;
        step_n = 0;
        if (held_ok && unit >= LOW_FIRST && unit <= LOW_LAST)
        begin
            hi_off = {5'd0, held_unit} - {5'd0, HIGH_FIRST};
            lo_off = {5'd0, unit} - {5'd0, LOW_FIRST};
            append_cp(SUPP_BASE + ((hi_off << 10) | lo_off));
            held_ok = 1'b0;
            held_unit = 16'h0000;
        end
        else
        begin
            if (held_ok)
            begin
                append_cp({5'd0, held_unit});
                held_ok = 1'b0;
                held_unit = 16'h0000;
            end
            if (unit >= HIGH_FIRST && unit <= HIGH_LAST && !last)
            begin
                held_unit = unit;
                held_ok = 1'b1;
            end
            else
                append_cp({5'd0, unit});
        end
    endfunction

    always @(posedge clk)
    begin
        utf8_beat_t got;
        utf8_beat_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                transcode_unit(s_axis_tdata, s_axis_tlast);
                if (units_taken < N_DIR)
                begin
                    if (dir_rows[units_taken].nexp != 2'd0)
                    begin
                        step_n = int'(dir_rows[units_taken].nexp);
                        step_bytes[0] = dir_rows[units_taken].bytes[23:16];
                        step_bytes[1] = dir_rows[units_taken].bytes[15:8];
                        step_bytes[2] = dir_rows[units_taken].bytes[7:0];
                    end
                end
                for (int k = 0; k < step_n; k++)
                begin
                    want.data       = step_bytes[k];
                    want.run_last   = (k == step_n - 1);
                    want.string_end = (k == step_n - 1) && s_axis_tlast;
                    pending_beats = {pending_beats, want};
                end
                units_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data       = m_axis_tdata;
                got.run_last   = m_axis_tuser[0];
                got.string_end = m_axis_tlast;
                if (pending_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected beat byte %h run_last %b string_end %b",
                                 got.data, got.run_last, got.string_end);
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb: mismatch: expected byte %h run_last %b ",
                                      "string_end %b, got byte %h run_last %b string_end %b"},
                                     want.data, want.run_last, want.string_end,
                                     got.data, got.run_last, got.string_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (jitter_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic last);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= unit;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        units_sent++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed strings with random content; some lone surrogates and noise.
    task automatic send_string();
        int          chars;
        logic        at_end;
        logic [15:0] hi;
        logic [15:0] lo;
        chars = int'($urandom_range(1, 6));
        for (int c = 0; c < chars; c++)
        begin
            at_end = (c == chars - 1);
            case ($urandom_range(0, 9))
                0, 1, 2: send_unit(16'($urandom_range(0, 'h7F)), at_end);
                3, 4:    send_unit(16'($urandom_range('h80, 'h7FF)), at_end);
                5:       send_unit(16'($urandom_range('h800, HIGH_FIRST - 1)), at_end);
                6:       send_unit(16'($urandom_range(LOW_LAST + 1, 'hFFFF)), at_end);
                7, 8:
                begin
                    hi = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
                    lo = 16'($urandom_range(LOW_FIRST, LOW_LAST));
                    send_unit(hi, 1'b0);
                    send_unit(lo, at_end);
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), at_end);
                        1:       send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), at_end);
                        default: send_unit(16'($urandom), at_end);
                    endcase
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        jitter_on = 1'b1;
        for (int i = 0; i < N_DIR; i++)
            send_unit(dir_rows[i].unit, dir_rows[i].last);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        long_hold_pending = 1'b1;
        while (units_sent < N_DIR + RAND_UNITS)
        begin
            if (units_sent >= N_DIR + RAND_UNITS - CALM_UNITS)
                jitter_on = 1'b0;
            send_string();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
